// ===== sv/ppf_pkg.sv =====
`default_nettype none
package ppf_pkg;

    localparam int MAX_VERT    = 1024;
    localparam int ADDR_W      = 10;
    localparam int CNT_W       = 11;
    localparam int MAX_WAG     = 16;
    localparam int SQRT_LAST   = 24;
    localparam int CORDIC_LAST = 20;
    localparam int DIV_LAST    = 57;
    localparam int NUM_W       = 58;
    localparam int CW          = 48;
    localparam int ZW          = 25;
    localparam logic [31:0] LEN_MAX = 32'h7FFF_FFFF;
    localparam logic signed [ZW-1:0] HEAD_LIM  = 25'sd23040;
    localparam logic signed [ZW-1:0] QUARTER_Z = 25'sd2949120;

    typedef enum logic [2:0] {
        ST_PLACED = 3'd0,
        ST_STORED = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_NOWAG  = 3'd4
    } t_stat;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_DIFF, OP_SQX, OP_SQY, OP_SQRT, OP_APPEND,
        OP_CLAMP, OP_SADDR, OP_SCMP, OP_RDS, OP_RDS1, OP_RDE,
        OP_CINIT, OP_CITER, OP_CFIN, OP_MUL0, OP_MUL1, OP_DIV,
        OP_INTERP, OP_EMITW, OP_EMITS, OP_NEXT
    } t_op;

    typedef struct packed {
        t_op   op;
        t_stat code;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic n_full;
        logic n_zero;
        logic n_one;
        logic cnt_zero;
        logic search_done;
        logic sqrt_done;
        logic cordic_done;
        logic div_done;
        logic out_free;
        logic last_wagon;
    } t_sts;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] heading;
        logic [3:0]         wagon_index;
        t_stat              status;
        logic               last;
    } t_result;

    function automatic logic [20:0] atan_step(input logic [4:0] k);
        logic [20:0] v;
        case (k)
            5'd0:    v = 21'd1474560;
            5'd1:    v = 21'd870484;
            5'd2:    v = 21'd459940;
            5'd3:    v = 21'd233473;
            5'd4:    v = 21'd117189;
            5'd5:    v = 21'd58652;
            5'd6:    v = 21'd29333;
            5'd7:    v = 21'd14667;
            5'd8:    v = 21'd7334;
            5'd9:    v = 21'd3667;
            5'd10:   v = 21'd1833;
            5'd11:   v = 21'd917;
            5'd12:   v = 21'd458;
            5'd13:   v = 21'd229;
            5'd14:   v = 21'd115;
            5'd15:   v = 21'd57;
            5'd16:   v = 21'd29;
            5'd17:   v = 21'd14;
            5'd18:   v = 21'd7;
            5'd19:   v = 21'd4;
            5'd20:   v = 21'd2;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [23:0] sat_pos(input logic signed [59:0] v);
        logic signed [23:0] r;
        if (v > 60'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -60'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/ppf_in_if.sv =====
`default_nettype none
interface ppf_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [31:0] head_distance;
    logic [4:0]         wagon_count;

    modport source (output valid, kind, point_x, point_y, head_distance, wagon_count,
                    input ready);
    modport sink (input valid, kind, point_x, point_y, head_distance, wagon_count,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/ppf_out_if.sv =====
`default_nettype none
interface ppf_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] heading;
    logic [3:0]         wagon_index;
    logic [2:0]         status;
    logic               last;

    modport source (output valid, pos_x, pos_y, heading, wagon_index, status, last,
                    input ready);
    modport sink (input valid, pos_x, pos_y, heading, wagon_index, status, last,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/ppf_ctrl.sv =====
`default_nettype none
module ppf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ppf_pkg::t_sts i_sts,
    output ppf_pkg::t_cmd      o_cmd
);

    typedef enum logic [22:0] {
        S_IDLE   = 23'h000001,
        S_DISP   = 23'h000002,
        S_ADIFF  = 23'h000004,
        S_ASQX   = 23'h000008,
        S_ASQY   = 23'h000010,
        S_ASQRT  = 23'h000020,
        S_AWR    = 23'h000040,
        S_EMITS  = 23'h000080,
        S_QCLAMP = 23'h000100,
        S_SADDR  = 23'h000200,
        S_SCMP   = 23'h000400,
        S_RDS    = 23'h000800,
        S_RDS1   = 23'h001000,
        S_RDE    = 23'h002000,
        S_CINIT  = 23'h004000,
        S_CITER  = 23'h008000,
        S_CFIN   = 23'h010000,
        S_MUL0   = 23'h020000,
        S_MUL1   = 23'h040000,
        S_DIV    = 23'h080000,
        S_INTERP = 23'h100000,
        S_EMITW  = 23'h200000,
        S_NEXT   = 23'h400000
    } t_state;

    t_state        r_state, n_state;
    ppf_pkg::t_stat r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ppf_pkg::ST_PLACED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_in_ready = 1'b0;
        o_cmd.op   = ppf_pkg::OP_NONE;
        o_cmd.code = r_code;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    o_cmd.op = ppf_pkg::OP_LATCH;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_sts.kind) begin
                    if (i_sts.n_full) begin
                        n_code  = ppf_pkg::ST_FULL;
                        n_state = S_EMITS;
                    end else if (i_sts.n_zero) begin
                        n_state = S_AWR;
                    end else begin
                        n_state = S_ADIFF;
                    end
                end else if (i_sts.n_zero) begin
                    n_code  = ppf_pkg::ST_EMPTY;
                    n_state = S_EMITS;
                end else if (i_sts.cnt_zero) begin
                    n_code  = ppf_pkg::ST_NOWAG;
                    n_state = S_EMITS;
                end else begin
                    n_state = S_QCLAMP;
                end
            end
            S_ADIFF: begin
                o_cmd.op = ppf_pkg::OP_DIFF;
                n_state  = S_ASQX;
            end
            S_ASQX: begin
                o_cmd.op = ppf_pkg::OP_SQX;
                n_state  = S_ASQY;
            end
            S_ASQY: begin
                o_cmd.op = ppf_pkg::OP_SQY;
                n_state  = S_ASQRT;
            end
            S_ASQRT: begin
                o_cmd.op = ppf_pkg::OP_SQRT;
                if (i_sts.sqrt_done) begin
                    n_state = S_AWR;
                end
            end
            S_AWR: begin
                o_cmd.op = ppf_pkg::OP_APPEND;
                n_code   = ppf_pkg::ST_STORED;
                n_state  = S_EMITS;
            end
            S_EMITS: begin
                if (i_sts.out_free) begin
                    o_cmd.op = ppf_pkg::OP_EMITS;
                    n_state  = S_IDLE;
                end
            end
            S_QCLAMP: begin
                o_cmd.op = ppf_pkg::OP_CLAMP;
                n_state  = S_SADDR;
            end
            S_SADDR: begin
                if (i_sts.search_done) begin
                    n_state = S_RDS;
                end else begin
                    o_cmd.op = ppf_pkg::OP_SADDR;
                    n_state  = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.op = ppf_pkg::OP_SCMP;
                n_state  = S_SADDR;
            end
            S_RDS: begin
                o_cmd.op = ppf_pkg::OP_RDS;
                n_state  = S_RDS1;
            end
            S_RDS1: begin
                o_cmd.op = ppf_pkg::OP_RDS1;
                n_state  = S_RDE;
            end
            S_RDE: begin
                o_cmd.op = ppf_pkg::OP_RDE;
                n_state  = i_sts.n_one ? S_INTERP : S_CINIT;
            end
            S_CINIT: begin
                o_cmd.op = ppf_pkg::OP_CINIT;
                n_state  = S_CITER;
            end
            S_CITER: begin
                o_cmd.op = ppf_pkg::OP_CITER;
                if (i_sts.cordic_done) begin
                    n_state = S_CFIN;
                end
            end
            S_CFIN: begin
                o_cmd.op = ppf_pkg::OP_CFIN;
                n_state  = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.op = ppf_pkg::OP_MUL0;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = ppf_pkg::OP_MUL1;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = ppf_pkg::OP_DIV;
                if (i_sts.div_done) begin
                    n_state = S_INTERP;
                end
            end
            S_INTERP: begin
                o_cmd.op = ppf_pkg::OP_INTERP;
                n_state  = S_EMITW;
            end
            S_EMITW: begin
                if (i_sts.out_free) begin
                    o_cmd.op = ppf_pkg::OP_EMITW;
                    n_state  = i_sts.last_wagon ? S_IDLE : S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.op = ppf_pkg::OP_NEXT;
                n_state  = S_SADDR;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/ppf_dpath.sv =====
`default_nettype none
module ppf_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ppf_pkg::t_cmd      i_cmd,
    output ppf_pkg::t_sts           o_sts,
    input  wire logic               i_kind,
    input  wire logic signed [23:0] i_point_x,
    input  wire logic signed [23:0] i_point_y,
    input  wire logic signed [31:0] i_head_distance,
    input  wire logic [4:0]         i_wagon_count,
    input  wire logic               i_cfg_we,
    input  wire logic [23:0]        i_cfg_wdata,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output ppf_pkg::t_result        o_out
);

    logic signed [23:0] mem_x [ppf_pkg::MAX_VERT];
    logic signed [23:0] mem_y [ppf_pkg::MAX_VERT];
    logic [31:0]        mem_l [ppf_pkg::MAX_VERT];

    logic signed [23:0] r_rd_x, r_rd_y;
    logic [31:0]        r_rd_l;

    logic                           r_kind;
    logic signed [23:0]             r_ix, r_iy;
    logic signed [31:0]             r_head;
    logic [4:0]                     r_cntw;
    logic [23:0]                    r_pitch;
    logic [ppf_pkg::CNT_W-1:0]      r_n;
    logic signed [24:0]             r_dx, r_dy;
    logic [31:0]                    r_base;
    logic [49:0]                    r_sq;
    logic [50:0]                    r_rem, r_root, r_bit;
    logic [5:0]                     r_cnt;
    logic signed [33:0]             r_d, r_e;
    logic [3:0]                     r_i;
    logic [ppf_pkg::ADDR_W-1:0]     r_lo, r_hi;
    logic signed [23:0]             r_sx, r_sy, r_posx, r_posy;
    logic [31:0]                    r_ls, r_seg;
    logic signed [ppf_pkg::CW-1:0]  r_cx, r_cy;
    logic signed [ppf_pkg::ZW-1:0]  r_cz;
    logic signed [15:0]             r_hd;
    logic [ppf_pkg::NUM_W-1:0]      r_numx, r_numy;
    logic [31:0]                    r_remx, r_remy;
    logic                           r_ov;
    ppf_pkg::t_result               r_o;

    logic [ppf_pkg::CNT_W-1:0]      n_m1, n_m2, mid_w;
    logic [ppf_pkg::ADDR_W-1:0]     mid, s_idx, rd_addr;
    logic                           n_zero, n_one, last_wagon, out_free;
    logic signed [49:0]             sqx, sqy;
    logic [50:0]                    sqt;
    logic [32:0]                    len_sum;
    logic [31:0]                    len_new;
    logic signed [ppf_pkg::CW-1:0]  xe, ye, xs, ys;
    logic signed [ppf_pkg::ZW-1:0]  at, zq, zc;
    logic [24:0]                    absdx, absdy;
    logic [33:0]                    abse;
    logic [41:0]                    plx, ply;
    logic [40:0]                    phx, phy;
    logic [32:0]                    tx, ty;
    logic                           gex, gey, negx, negy;
    logic signed [59:0]             qx, qy;

    assign n_m1       = r_n - 11'd1;
    assign n_m2       = r_n - 11'd2;
    assign n_zero     = (r_n == '0);
    assign n_one      = (r_n == 11'd1);
    assign mid_w      = 11'(r_lo) + ((11'(r_hi) - 11'(r_lo) + 11'd1) >> 1);
    assign mid        = mid_w[ppf_pkg::ADDR_W-1:0];
    assign s_idx      = n_one ? '0 :
                        ((r_lo == n_m1[ppf_pkg::ADDR_W-1:0]) ? n_m2[ppf_pkg::ADDR_W-1:0] : r_lo);
    assign last_wagon = ((5'(r_i) + 5'd1) == r_cntw);
    assign out_free   = !r_ov || i_out_ready;

    always_comb begin
        case (i_cmd.op)
            ppf_pkg::OP_SADDR, ppf_pkg::OP_SCMP: rd_addr = mid;
            ppf_pkg::OP_RDS:                     rd_addr = s_idx;
            ppf_pkg::OP_RDS1:                    rd_addr = s_idx + 10'd1;
            default:                             rd_addr = n_m1[ppf_pkg::ADDR_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
        r_rd_l <= mem_l[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ppf_pkg::OP_APPEND) begin
            mem_x[r_n[ppf_pkg::ADDR_W-1:0]] <= r_ix;
            mem_y[r_n[ppf_pkg::ADDR_W-1:0]] <= r_iy;
            mem_l[r_n[ppf_pkg::ADDR_W-1:0]] <= len_new;
        end
    end

    assign sqx     = r_dx * r_dx;
    assign sqy     = r_dy * r_dy;
    assign sqt     = r_root + r_bit;
    assign len_sum = {1'b0, r_base} + {8'b0, r_root[24:0]};
    assign len_new = n_zero ? 32'd0 :
                     (len_sum > {1'b0, ppf_pkg::LEN_MAX} ? ppf_pkg::LEN_MAX : len_sum[31:0]);

    assign xe = {{3{r_dx[24]}}, r_dx, 20'b0};
    assign ye = {{3{r_dy[24]}}, r_dy, 20'b0};
    assign xs = r_cx >>> r_cnt[4:0];
    assign ys = r_cy >>> r_cnt[4:0];
    assign at = $signed({4'b0, ppf_pkg::atan_step(r_cnt[4:0])});

    always_comb begin
        if (!r_cz[ppf_pkg::ZW-1]) begin
            zq = (r_cz + 25'sd128) >>> 8;
        end else begin
            zq = -((-r_cz + 25'sd128) >>> 8);
        end
        if (zq > ppf_pkg::HEAD_LIM) begin
            zc = ppf_pkg::HEAD_LIM;
        end else if (zq < -ppf_pkg::HEAD_LIM) begin
            zc = -ppf_pkg::HEAD_LIM;
        end else begin
            zc = zq;
        end
    end

    assign absdx = r_dx[24] ? 25'(-r_dx) : 25'(r_dx);
    assign absdy = r_dy[24] ? 25'(-r_dy) : 25'(r_dy);
    assign abse  = r_e[33] ? 34'(-r_e) : 34'(r_e);
    assign plx   = absdx * abse[16:0];
    assign ply   = absdy * abse[16:0];
    assign phx   = absdx * abse[32:17];
    assign phy   = absdy * abse[32:17];

    assign tx  = {r_remx, r_numx[ppf_pkg::NUM_W-1]};
    assign ty  = {r_remy, r_numy[ppf_pkg::NUM_W-1]};
    assign gex = (tx >= {1'b0, r_seg});
    assign gey = (ty >= {1'b0, r_seg});

    assign negx = r_dx[24] ^ r_e[33];
    assign negy = r_dy[24] ^ r_e[33];
    assign qx   = (negx ? -$signed({2'b0, r_numx}) : $signed({2'b0, r_numx}))
                  + 60'(r_sx);
    assign qy   = (negy ? -$signed({2'b0, r_numy}) : $signed({2'b0, r_numy}))
                  + 60'(r_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= '0;
            r_pitch <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pitch <= i_cfg_wdata;
            end
            if (i_cmd.op == ppf_pkg::OP_APPEND) begin
                r_n <= r_n + 11'd1;
            end
            if (i_cmd.op == ppf_pkg::OP_EMITW || i_cmd.op == ppf_pkg::OP_EMITS) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ppf_pkg::OP_LATCH: begin
                r_kind <= i_kind;
                r_ix   <= i_point_x;
                r_iy   <= i_point_y;
                r_head <= i_head_distance;
                r_cntw <= (i_wagon_count > 5'(ppf_pkg::MAX_WAG)) ?
                          5'(ppf_pkg::MAX_WAG) : i_wagon_count;
            end
            ppf_pkg::OP_DIFF: begin
                r_dx   <= 25'(r_ix) - 25'(r_rd_x);
                r_dy   <= 25'(r_iy) - 25'(r_rd_y);
                r_base <= r_rd_l;
            end
            ppf_pkg::OP_SQX: begin
                r_sq <= sqx;
            end
            ppf_pkg::OP_SQY: begin
                r_rem  <= {1'b0, r_sq} + 51'(sqy);
                r_root <= '0;
                r_bit  <= 51'(1) << 48;
                r_cnt  <= '0;
            end
            ppf_pkg::OP_SQRT: begin
                if (r_rem >= sqt) begin
                    r_rem  <= r_rem - sqt;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 6'd1;
            end
            ppf_pkg::OP_CLAMP: begin
                if (r_head[31]) begin
                    r_d <= '0;
                end else if (34'(r_head) > $signed({2'b0, r_rd_l})) begin
                    r_d <= $signed({2'b0, r_rd_l});
                end else begin
                    r_d <= 34'(r_head);
                end
                r_i  <= '0;
                r_lo <= '0;
                r_hi <= n_m1[ppf_pkg::ADDR_W-1:0];
            end
            ppf_pkg::OP_SCMP: begin
                if ($signed({2'b0, r_rd_l}) <= r_d) begin
                    r_lo <= mid;
                end else begin
                    r_hi <= mid - 10'd1;
                end
            end
            ppf_pkg::OP_RDS1: begin
                r_sx <= r_rd_x;
                r_sy <= r_rd_y;
                r_ls <= r_rd_l;
            end
            ppf_pkg::OP_RDE: begin
                r_dx  <= 25'(r_rd_x) - 25'(r_sx);
                r_dy  <= 25'(r_rd_y) - 25'(r_sy);
                r_seg <= r_rd_l - r_ls;
                r_e   <= r_d - $signed({2'b0, r_ls});
            end
            ppf_pkg::OP_CINIT: begin
                if (r_dx[24]) begin
                    if (!r_dy[24]) begin
                        r_cx <= ye;
                        r_cy <= -xe;
                        r_cz <= ppf_pkg::QUARTER_Z;
                    end else begin
                        r_cx <= -ye;
                        r_cy <= xe;
                        r_cz <= -ppf_pkg::QUARTER_Z;
                    end
                end else begin
                    r_cx <= xe;
                    r_cy <= ye;
                    r_cz <= '0;
                end
                r_cnt <= '0;
            end
            ppf_pkg::OP_CITER: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + at;
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - at;
                end
                r_cnt <= r_cnt + 6'd1;
            end
            ppf_pkg::OP_CFIN: begin
                r_hd <= (r_dx == '0 && r_dy == '0) ? 16'sd0 : 16'(zc);
            end
            ppf_pkg::OP_MUL0: begin
                r_numx <= 58'(plx);
                r_numy <= 58'(ply);
            end
            ppf_pkg::OP_MUL1: begin
                r_numx <= r_numx + {phx, 17'b0} + 58'(r_seg >> 1);
                r_numy <= r_numy + {phy, 17'b0} + 58'(r_seg >> 1);
                r_remx <= '0;
                r_remy <= '0;
                r_cnt  <= '0;
            end
            ppf_pkg::OP_DIV: begin
                r_remx <= gex ? 32'(tx - {1'b0, r_seg}) : tx[31:0];
                r_remy <= gey ? 32'(ty - {1'b0, r_seg}) : ty[31:0];
                r_numx <= {r_numx[ppf_pkg::NUM_W-2:0], gex};
                r_numy <= {r_numy[ppf_pkg::NUM_W-2:0], gey};
                r_cnt  <= r_cnt + 6'd1;
            end
            ppf_pkg::OP_INTERP: begin
                if (n_one || r_seg == '0 || r_e == '0) begin
                    r_posx <= r_sx;
                    r_posy <= r_sy;
                end else begin
                    r_posx <= ppf_pkg::sat_pos(qx);
                    r_posy <= ppf_pkg::sat_pos(qy);
                end
                if (n_one) begin
                    r_hd <= '0;
                end
            end
            ppf_pkg::OP_EMITW: begin
                r_o.pos_x       <= r_posx;
                r_o.pos_y       <= r_posy;
                r_o.heading     <= r_hd;
                r_o.wagon_index <= r_i;
                r_o.status      <= ppf_pkg::ST_PLACED;
                r_o.last        <= last_wagon;
            end
            ppf_pkg::OP_EMITS: begin
                r_o.pos_x       <= '0;
                r_o.pos_y       <= '0;
                r_o.heading     <= '0;
                r_o.wagon_index <= '0;
                r_o.status      <= i_cmd.code;
                r_o.last        <= 1'b1;
            end
            ppf_pkg::OP_NEXT: begin
                r_d  <= r_d - $signed({10'b0, r_pitch});
                r_i  <= r_i + 4'd1;
                r_lo <= '0;
                r_hi <= n_m1[ppf_pkg::ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.kind        = r_kind;
        o_sts.n_full      = (r_n == 11'(ppf_pkg::MAX_VERT));
        o_sts.n_zero      = n_zero;
        o_sts.n_one       = n_one;
        o_sts.cnt_zero    = (r_cntw == '0);
        o_sts.search_done = (r_lo >= r_hi);
        o_sts.sqrt_done   = (r_cnt == 6'(ppf_pkg::SQRT_LAST));
        o_sts.cordic_done = (r_cnt == 6'(ppf_pkg::CORDIC_LAST));
        o_sts.div_done    = (r_cnt == 6'(ppf_pkg::DIV_LAST));
        o_sts.out_free    = out_free;
        o_sts.last_wagon  = last_wagon;
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_o;

endmodule
`default_nettype wire

// ===== sv/polyline_path_follower.sv =====
`default_nettype none
// Polyline path follower: stores up to 1024 points with their running arc length and places
// trains of up to 16 wagons along the path. One item is handled at a time; input is taken
// again once the last result beat has been loaded into the output register, which holds it
// while the next item already runs. Appending the first point skips the square root; any later
// point runs the 25-step bit-serial square root. A placement runs, for each wagon, a binary
// search over the arc-length memory (each probe an address state, then a compare state), 21
// CORDIC steps for the heading and a 58-step restoring divider for the interpolation (both
// skipped on a one-point path), then waits until the output register is free. Point memory
// needs no clearing after reset; only entries already written ever affect a result.
module polyline_path_follower (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ppf_in_if.sink           i_in,
    ppf_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [23:0] i_cfg_wdata
);

    ppf_pkg::t_cmd    cmd;
    ppf_pkg::t_sts    sts;
    ppf_pkg::t_result res;
    logic             in_ready;
    logic             out_valid;

    ppf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppf_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_kind          (i_in.kind),
        .i_point_x       (i_in.point_x),
        .i_point_y       (i_in.point_y),
        .i_head_distance (i_in.head_distance),
        .i_wagon_count   (i_in.wagon_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (out_valid),
        .o_out           (res)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.pos_x       = res.pos_x;
    assign o_out.pos_y       = res.pos_y;
    assign o_out.heading     = res.heading;
    assign o_out.wagon_index = res.wagon_index;
    assign o_out.status      = res.status;
    assign o_out.last        = res.last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == ppf_pkg::OP_EMITW || cmd.op == ppf_pkg::OP_EMITS) |-> sts.out_free)
        else $error("result loaded over an untaken beat");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again straight after a beat");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ppf_pkg::ST_PLACED) |-> o_out.last)
        else $error("status beat without last");

endmodule
`default_nettype wire

// ===== bench/tb_polyline_path_follower.sv =====
`default_nettype none
module tb_polyline_path_follower;
    timeunit 1ns;
    timeprecision 1ps;

    class path_scoreboard;
        longint  vx [ppf_pkg::MAX_VERT];
        longint  vy [ppf_pkg::MAX_VERT];
        longint  arc_len [ppf_pkg::MAX_VERT];
        int      n_pts;
        longint  pitch;
        ppf_pkg::t_result placements [$];
        int      errors;
        int      beats;
        longint  atan_lut [21] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
                                   14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                                   14, 7, 4, 2};

        function new();
            n_pts = 0;
            pitch = 0;
            errors = 0;
            beats = 0;
        endfunction

        function longint rnd_div(longint n, longint d);
            if (n >= 0) return (n + d / 2) / d;
            return -((-n + d / 2) / d);
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint root(longint v);
            longint r, b;
            r = 0;
            b = 64'sd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint bearing(longint dx, longint dy);
            longint x, y, z, t, xs, ys;
            if (dx == 0 && dy == 0) return 0;
            x = dx * 1048576;
            y = dy * 1048576;
            z = 0;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = 2949120;
                end else begin
                    t = x; x = -y; y = t; z = -2949120;
                end
            end
            for (int k = 0; k < 21; k++) begin
                xs = x >>> k;
                ys = y >>> k;
                if (y > 0) begin
                    x = x + ys; y = y - xs; z = z + atan_lut[k];
                end else begin
                    x = x - ys; y = y + xs; z = z - atan_lut[k];
                end
            end
            return clip(rnd_div(z, 256), -23040, 23040);
        endfunction

        function void push(longint px, longint py, longint hd, int idx, ppf_pkg::t_stat st,
                           bit lst);
            ppf_pkg::t_result r;
            r.pos_x = px[23:0];
            r.pos_y = py[23:0];
            r.heading = hd[15:0];
            r.wagon_index = idx[3:0];
            r.status = st;
            r.last = lst;
            placements.insert(placements.size(), r);
        endfunction

        function void locate(longint d, int idx, bit lst);
            int lo, hi, mid, s;
            longint sx, sy, dx, dy, seg, hd, px, py;
            if (n_pts < 2) begin
                push(vx[0], vy[0], 0, idx, ppf_pkg::ST_PLACED, lst);
                return;
            end
            lo = 0;
            hi = n_pts - 1;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                if (arc_len[mid] <= d) lo = mid; else hi = mid - 1;
            end
            s = lo > n_pts - 2 ? n_pts - 2 : lo;
            sx = vx[s];
            sy = vy[s];
            dx = vx[s+1] - sx;
            dy = vy[s+1] - sy;
            hd = bearing(dx, dy);
            seg = arc_len[s+1] - arc_len[s];
            if (seg <= 0 || arc_len[s] == d) begin
                px = sx;
                py = sy;
            end else begin
                px = clip(sx + rnd_div(dx * (d - arc_len[s]), seg), -8388608, 8388607);
                py = clip(sy + rnd_div(dy * (d - arc_len[s]), seg), -8388608, 8388607);
            end
            push(px, py, hd, idx, ppf_pkg::ST_PLACED, lst);
        endfunction

        function void note_item(bit kind, logic signed [23:0] x, logic signed [23:0] y,
                                logic signed [31:0] head, logic [4:0] cnt);
            longint dx, dy, sum, h;
            int c;
            if (!kind) begin
                if (n_pts >= ppf_pkg::MAX_VERT) begin
                    push(0, 0, 0, 0, ppf_pkg::ST_FULL, 1);
                    return;
                end
                vx[n_pts] = x;
                vy[n_pts] = y;
                if (n_pts == 0) begin
                    arc_len[0] = 0;
                end else begin
                    dx = longint'(x) - vx[n_pts-1];
                    dy = longint'(y) - vy[n_pts-1];
                    sum = arc_len[n_pts-1] + root(dx * dx + dy * dy);
                    arc_len[n_pts] = sum > 2147483647 ? 2147483647 : sum;
                end
                n_pts++;
                push(0, 0, 0, 0, ppf_pkg::ST_STORED, 1);
            end else if (n_pts == 0) begin
                push(0, 0, 0, 0, ppf_pkg::ST_EMPTY, 1);
            end else if (cnt == 0) begin
                push(0, 0, 0, 0, ppf_pkg::ST_NOWAG, 1);
            end else begin
                c = cnt > ppf_pkg::MAX_WAG ? ppf_pkg::MAX_WAG : cnt;
                h = clip(head, 0, arc_len[n_pts-1]);
                for (int i = 0; i < c; i++) locate(h - i * pitch, i, i + 1 == c);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH beat %0d: %s", beats, msg);
        endtask

        task check(ppf_pkg::t_result got);
            ppf_pkg::t_result e;
            beats++;
            if (placements.size() == 0) begin
                report("result beat with nothing pending");
                return;
            end
            e = placements.pop_front();
            if (got.pos_x !== e.pos_x)
                report($sformatf("pos_x %0d, want %0d", got.pos_x, e.pos_x));
            if (got.pos_y !== e.pos_y)
                report($sformatf("pos_y %0d, want %0d", got.pos_y, e.pos_y));
            if (got.heading !== e.heading)
                report($sformatf("heading %0d, want %0d", got.heading, e.heading));
            if (got.wagon_index !== e.wagon_index)
                report($sformatf("wagon_index %0d, want %0d", got.wagon_index,
                                 e.wagon_index));
            if (got.status !== e.status)
                report($sformatf("status %0d, want %0d", got.status, e.status));
            if (got.last !== e.last)
                report($sformatf("last %0b, want %0b", got.last, e.last));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [23:0] i_cfg_wdata = '0;
    bit          quiet = 0;
    int          cycles = 0;
    int          sent = 0;
    int          sink_hold = 0;
    int          prev_x = 0;
    int          prev_y = 0;

    ppf_in_if  in_bus ();
    ppf_out_if out_bus ();
    path_scoreboard sb = new();

    polyline_path_follower uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        in_bus.valid = 1'b0;
        in_bus.kind = 1'b0;
        in_bus.point_x = '0;
        in_bus.point_y = '0;
        in_bus.head_distance = '0;
        in_bus.wagon_count = '0;
        out_bus.ready = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        ppf_pkg::t_result r;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            r.pos_x = out_bus.pos_x;
            r.pos_y = out_bus.pos_y;
            r.heading = out_bus.heading;
            r.wagon_index = out_bus.wagon_index;
            r.status = ppf_pkg::t_stat'(out_bus.status);
            r.last = out_bus.last;
            sb.check(r);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready = 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            out_bus.ready = 1'b0;
        end else if (!quiet && $urandom_range(5) == 0) begin
            sink_hold = $urandom_range(1, 7) - 1;
            out_bus.ready = 1'b0;
        end else begin
            out_bus.ready = 1'b1;
        end
    end

    task automatic send(bit kind, logic signed [23:0] x, logic signed [23:0] y,
                        logic signed [31:0] head, logic [4:0] cnt);
        if (!quiet && $urandom_range(3) == 0) begin
            in_bus.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_bus.valid = 1'b1;
        in_bus.kind = kind;
        in_bus.point_x = x;
        in_bus.point_y = y;
        in_bus.head_distance = head;
        in_bus.wagon_count = cnt;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.note_item(kind, x, y, head, cnt);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic append(int x, int y);
        prev_x = x;
        prev_y = y;
        send(1'b0, x, y, $urandom, $urandom);
    endtask

    task automatic query(int head, int cnt);
        send(1'b1, $urandom, $urandom, head, cnt);
    endtask

    task automatic settle();
        in_bus.valid = 1'b0;
        while (sb.placements.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_pitch(logic [23:0] v);
        settle();
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.pitch = v;
    endtask

    task automatic walk_point(int span);
        int x, y;
        x = prev_x + $urandom_range(0, 2 * span) - span;
        y = prev_y + $urandom_range(0, 2 * span) - span;
        if (x > 8388607) x = 8388607;
        if (x < -8388608) x = -8388608;
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        append(x, y);
    endtask

    task automatic random_query();
        int head, cnt, total;
        total = sb.n_pts > 0 ? int'(sb.arc_len[sb.n_pts-1]) : 0;
        case ($urandom_range(9))
            0:       head = $urandom;
            1:       head = -$urandom_range(0, 100000);
            2:       head = total + $urandom_range(0, 100000);
            default: head = $urandom_range(0, total);
        endcase
        case ($urandom_range(11))
            0:       cnt = 0;
            1:       cnt = $urandom_range(17, 31);
            default: cnt = $urandom_range(1, 16);
        endcase
        query(head, cnt);
    endtask

    task automatic random_phase(int items, int span);
        repeat (items) begin
            if ($urandom_range(2) == 0) walk_point(span);
            else random_query();
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        set_pitch(24'd0);

        // directed: empty path, single point, degenerate and extreme segments
        query(100, 3);
        append(-8388608, 8388607);
        query(0, 2);
        query(-2147483648, 31);
        append(-8388608, 8388607);
        query(0, 1);
        append(8388607, -8388608);
        query(2147483647, 16);
        query(5000, 0);
        append(8388607, 8388607);
        append(0, 0);
        append(-1000, 0);
        append(-1000, -1000);
        set_pitch(24'h000500);
        query(2147483647, 16);
        query(-2147483648, 5);
        query(int'(sb.arc_len[3]), 4);
        query(int'(sb.arc_len[1]), 2);
        set_pitch(24'hFFFFFF);
        query(2147483647, 16);
        query(30000000, 17);

        set_pitch($urandom_range(1, 4000));
        random_phase(60, 3000);
        set_pitch($urandom_range(0, 24'hFFFFFF));
        random_phase(60, 300000);
        set_pitch(24'hFFFFFF);
        random_phase(30, 8000000);
        set_pitch(24'd0);
        quiet = 1;
        random_phase(40, 2000);

        set_pitch($urandom_range(1, 50000));
        query(2147483647, 16);
        query(-5, 16);

        settle();
        repeat (200) @(negedge i_clk);
        $display("Covered %0d items and %0d result beats over %0d path points,",
                 sent, sb.beats, sb.n_pts);
        $display("with pitch changes, clamping, extrapolation and wagon saturation.");
        if (sb.errors == 0 && sb.placements.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
